// ===== hw/rtl/wssc_pkg.sv =====
// Shared types, constants and saturation helpers for the wall sensor
// steering control core. No dependencies.
`default_nettype none

package wssc_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int GAIN_BITS     = 8;
  localparam int ERR_BITS      = 14;
  localparam int WIDE_ERR_BITS = SAMPLE_BITS + 3;
  localparam int DRIVE_BITS    = 16;
  localparam int PROD_BITS     = GAIN_BITS + WIDE_ERR_BITS + 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = SAMPLE_BITS;
  localparam int SPEED_BITS    = 3;
  localparam int WALL_BITS     = 8;

  localparam logic [SAMPLE_BITS-1:0] JUMP_THRESHOLD  = SAMPLE_BITS'(20);
  localparam logic [SAMPLE_BITS:0]   THRESHOLD_RAISE = (SAMPLE_BITS + 1)'(20);

  localparam logic [WALL_BITS-1:0] WALL_FRONT = 8'h88;
  localparam logic [WALL_BITS-1:0] WALL_RIGHT = 8'h44;
  localparam logic [WALL_BITS-1:0] WALL_LEFT  = 8'h11;

  localparam logic signed [WIDE_ERR_BITS-1:0] ERR_MAX =
    WIDE_ERR_BITS'((1 << (ERR_BITS - 1)) - 1);
  localparam logic signed [WIDE_ERR_BITS-1:0] ERR_MIN =
    WIDE_ERR_BITS'(-(1 << (ERR_BITS - 1)));
  localparam logic signed [PROD_BITS-1:0] DRIVE_MAX =
    PROD_BITS'((1 << (DRIVE_BITS - 1)) - 1);
  localparam logic signed [PROD_BITS-1:0] DRIVE_MIN =
    PROD_BITS'(-(1 << (DRIVE_BITS - 1)));

  typedef enum logic [1:0] {
    PH_SIDE  = 2'd0,
    PH_FRONT = 2'd1,
    PH_CTRL  = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BASE_LEFT        = 3'd0,
    REG_BASE_RIGHT       = 3'd1,
    REG_CTRL_THRE_LEFT   = 3'd2,
    REG_CTRL_THRE_RIGHT  = 3'd3,
    REG_GAIN_MODE_ZERO   = 3'd4,
    REG_GAIN_OTHER_MODES = 3'd5,
    REG_WALL_THRE_FRONT  = 3'd6,
    REG_WALL_THRE_SIDE   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] base_left;
    logic [SAMPLE_BITS-1:0] base_right;
    logic [SAMPLE_BITS-1:0] ctrl_thre_left;
    logic [SAMPLE_BITS-1:0] ctrl_thre_right;
    logic [GAIN_BITS-1:0]   gain_mode_zero;
    logic [GAIN_BITS-1:0]   gain_other_modes;
    logic [SAMPLE_BITS-1:0] wall_thre_front;
    logic [SAMPLE_BITS-1:0] wall_thre_side;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_BITS-1:0]   err;
    logic signed [DRIVE_BITS-1:0] drive_right;
    logic signed [DRIVE_BITS-1:0] drive_left;
  } steer_t;

  function automatic logic signed [ERR_BITS-1:0] sat_err(
    input logic signed [WIDE_ERR_BITS-1:0] v);
    logic signed [ERR_BITS-1:0] r;
    if (v > ERR_MAX) r = ERR_BITS'(ERR_MAX);
    else if (v < ERR_MIN) r = ERR_BITS'(ERR_MIN);
    else r = ERR_BITS'(v);
    return r;
  endfunction

  function automatic logic signed [DRIVE_BITS-1:0] sat_drive(
    input logic signed [PROD_BITS-1:0] v);
    logic signed [DRIVE_BITS-1:0] r;
    if (v > DRIVE_MAX) r = DRIVE_BITS'(DRIVE_MAX);
    else if (v < DRIVE_MIN) r = DRIVE_BITS'(DRIVE_MIN);
    else r = DRIVE_BITS'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wssc_cfg_regs.sv =====
// Configuration register file for the steering core.
// Depends on wssc_pkg for the register index codes and cfg_t.
`default_nettype none

module wssc_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [wssc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [wssc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output wssc_pkg::cfg_t                           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_left        <= '0;
      cfg.base_right       <= '0;
      cfg.ctrl_thre_left   <= '0;
      cfg.ctrl_thre_right  <= '0;
      cfg.gain_mode_zero   <= wssc_pkg::GAIN_BITS'(1);
      cfg.gain_other_modes <= wssc_pkg::GAIN_BITS'(1);
      cfg.wall_thre_front  <= '0;
      cfg.wall_thre_side   <= '0;
    end else if (cfg_we) begin
      unique case (wssc_pkg::cfg_reg_t'(cfg_index))
        wssc_pkg::REG_BASE_LEFT:        cfg.base_left       <= cfg_data;
        wssc_pkg::REG_BASE_RIGHT:       cfg.base_right      <= cfg_data;
        wssc_pkg::REG_CTRL_THRE_LEFT:   cfg.ctrl_thre_left  <= cfg_data;
        wssc_pkg::REG_CTRL_THRE_RIGHT:  cfg.ctrl_thre_right <= cfg_data;
        wssc_pkg::REG_GAIN_MODE_ZERO: begin
          cfg.gain_mode_zero <= cfg_data[wssc_pkg::GAIN_BITS-1:0];
        end
        wssc_pkg::REG_GAIN_OTHER_MODES: begin
          cfg.gain_other_modes <= cfg_data[wssc_pkg::GAIN_BITS-1:0];
        end
        wssc_pkg::REG_WALL_THRE_FRONT:  cfg.wall_thre_front <= cfg_data;
        wssc_pkg::REG_WALL_THRE_SIDE:   cfg.wall_thre_side  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wssc_steer_law.sv =====
// Steering law: jump-raised thresholds, lateral error, gain and saturation.
// Purely combinational; depends on wssc_pkg for cfg_t, steer_t and helpers.
`default_nettype none

module wssc_steer_law (
  input  wire logic [wssc_pkg::SAMPLE_BITS-1:0] latched_right,
  input  wire logic [wssc_pkg::SAMPLE_BITS-1:0] latched_left,
  input  wire logic [wssc_pkg::SAMPLE_BITS-1:0] prev_right,
  input  wire logic [wssc_pkg::SAMPLE_BITS-1:0] prev_left,
  input  wire wssc_pkg::cfg_t                   cfg,
  input  wire logic [wssc_pkg::SPEED_BITS-1:0]  speed_mode,
  output wssc_pkg::steer_t                      steer
);

  localparam int SB = wssc_pkg::SAMPLE_BITS;
  localparam int EW = wssc_pkg::WIDE_ERR_BITS;
  localparam int PW = wssc_pkg::PROD_BITS;

  logic [SB-1:0]               diff_r, diff_l;
  logic                        jump_r, jump_l;
  logic [SB:0]                 thr_r, thr_l;
  logic                        use_r, use_l;
  logic signed [SB:0]          dr, dl;
  logic signed [EW-1:0]        err_wide;
  logic signed [wssc_pkg::ERR_BITS-1:0] err;
  logic [wssc_pkg::GAIN_BITS-1:0] gain;
  logic signed [wssc_pkg::GAIN_BITS:0] gain_s;
  logic signed [PW-1:0]        prod;

  always_comb begin
    diff_r = (latched_right > prev_right) ? latched_right - prev_right
                                          : prev_right - latched_right;
    diff_l = (latched_left > prev_left) ? latched_left - prev_left
                                        : prev_left - latched_left;
    jump_r = diff_r > wssc_pkg::JUMP_THRESHOLD;
    jump_l = diff_l > wssc_pkg::JUMP_THRESHOLD;

    thr_r = {1'b0, cfg.ctrl_thre_right} + (jump_r ? wssc_pkg::THRESHOLD_RAISE : '0);
    thr_l = {1'b0, cfg.ctrl_thre_left} + (jump_l ? wssc_pkg::THRESHOLD_RAISE : '0);
    use_r = {1'b0, latched_right} > thr_r;
    use_l = {1'b0, latched_left} > thr_l;

    dr = $signed({1'b0, latched_right}) - $signed({1'b0, cfg.base_right});
    dl = $signed({1'b0, latched_left}) - $signed({1'b0, cfg.base_left});

    if (use_r && use_l) err_wide = EW'(dl) - EW'(dr);
    else if (use_r) err_wide = -(EW'(dr) + EW'(dr));
    else if (use_l) err_wide = EW'(dl) + EW'(dl);
    else err_wide = '0;
    err = wssc_pkg::sat_err(err_wide);

    gain   = (speed_mode == '0) ? cfg.gain_mode_zero : cfg.gain_other_modes;
    gain_s = $signed({1'b0, gain});
    prod   = PW'(gain_s) * PW'(err);

    steer.err         = err;
    steer.drive_left  = wssc_pkg::sat_drive(prod);
    steer.drive_right = wssc_pkg::sat_drive(-prod);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wall_sensor_steering_control_core.sv =====
// Wall sensor steering control core: one tick beat in, one result beat out,
// an item every cycle unless the output stalls. Each accepted tick's result
// is valid in the cycle after acceptance, held in the output register; input
// stalls only while it holds a stalled result. Ticks cycle through three phases:
// side samples latched, front samples latched, steering law run. The law
// (threshold compare, error, 8-bit gain multiply, saturation) sits in a single
// combinational stage between the state registers and the output register.
// Depends on wssc_pkg, wssc_cfg_regs and wssc_steer_law.
`default_nettype none

module wall_sensor_steering_control_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [wssc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [wssc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [wssc_pkg::SAMPLE_BITS-1:0]    right_sample,
  input  wire logic [wssc_pkg::SAMPLE_BITS-1:0]    left_sample,
  input  wire logic [wssc_pkg::SAMPLE_BITS-1:0]    front_right_sample,
  input  wire logic [wssc_pkg::SAMPLE_BITS-1:0]    front_left_sample,
  input  wire logic                                ctrl_enable,
  input  wire logic [wssc_pkg::SPEED_BITS-1:0]     speed_mode,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               phase_done,
  output logic signed [wssc_pkg::DRIVE_BITS-1:0]   drive_right,
  output logic signed [wssc_pkg::DRIVE_BITS-1:0]   drive_left,
  output logic signed [wssc_pkg::ERR_BITS-1:0]     steer_error,
  output logic [wssc_pkg::WALL_BITS-1:0]           wall_bits
);

  localparam int SB = wssc_pkg::SAMPLE_BITS;

  wssc_pkg::cfg_t   cfg;
  wssc_pkg::steer_t steer;
  wssc_pkg::phase_t phase, phase_next;

  logic          in_accept;
  logic          lat_side, lat_front, lat_ctrl, ctrl_run;
  logic [SB-1:0] latched_right, latched_left, latched_front_right, latched_front_left;
  logic [SB-1:0] latched_right_next, latched_left_next;
  logic [SB-1:0] latched_front_right_next, latched_front_left_next;
  logic [SB-1:0] prev_right, prev_left;
  logic signed [wssc_pkg::ERR_BITS-1:0]   error_reg, error_next;
  logic signed [wssc_pkg::DRIVE_BITS-1:0] drive_right_reg, drive_right_next;
  logic signed [wssc_pkg::DRIVE_BITS-1:0] drive_left_reg, drive_left_next;
  logic [wssc_pkg::WALL_BITS-1:0]         wall_next;

  wssc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wssc_steer_law u_law (
    .latched_right (latched_right),
    .latched_left  (latched_left),
    .prev_right    (prev_right),
    .prev_left     (prev_left),
    .cfg           (cfg),
    .speed_mode    (speed_mode),
    .steer         (steer)
  );

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    unique case (phase)
      wssc_pkg::PH_SIDE:  phase_next = wssc_pkg::PH_FRONT;
      wssc_pkg::PH_FRONT: phase_next = wssc_pkg::PH_CTRL;
      default:            phase_next = wssc_pkg::PH_SIDE;
    endcase
  end

  always_comb begin
    lat_side  = 1'b0;
    lat_front = 1'b0;
    lat_ctrl  = 1'b0;
    unique case (phase)
      wssc_pkg::PH_SIDE:  lat_side  = in_accept;
      wssc_pkg::PH_FRONT: lat_front = in_accept;
      wssc_pkg::PH_CTRL:  lat_ctrl  = in_accept;
      default: ;
    endcase
  end

  always_comb begin
    ctrl_run = lat_ctrl && ctrl_enable;

    latched_right_next       = lat_side  ? right_sample       : latched_right;
    latched_left_next        = lat_side  ? left_sample        : latched_left;
    latched_front_right_next = lat_front ? front_right_sample : latched_front_right;
    latched_front_left_next  = lat_front ? front_left_sample  : latched_front_left;

    error_next = ctrl_run ? steer.err : error_reg;
    if (ctrl_run) begin
      drive_right_next = steer.drive_right;
      drive_left_next  = steer.drive_left;
    end else if (lat_ctrl) begin
      drive_right_next = '0;
      drive_left_next  = '0;
    end else begin
      drive_right_next = drive_right_reg;
      drive_left_next  = drive_left_reg;
    end

    wall_next = '0;
    if (latched_front_left_next > cfg.wall_thre_front) wall_next |= wssc_pkg::WALL_FRONT;
    if (latched_right_next > cfg.wall_thre_side) wall_next |= wssc_pkg::WALL_RIGHT;
    if (latched_left_next > cfg.wall_thre_side) wall_next |= wssc_pkg::WALL_LEFT;
  end

  // Tick state: advance only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= wssc_pkg::PH_SIDE;
      latched_right       <= '0;
      latched_left        <= '0;
      latched_front_right <= '0;
      latched_front_left  <= '0;
      prev_right          <= '0;
      prev_left           <= '0;
      error_reg           <= '0;
      drive_right_reg     <= '0;
      drive_left_reg      <= '0;
    end else if (in_accept) begin
      phase               <= phase_next;
      latched_right       <= latched_right_next;
      latched_left        <= latched_left_next;
      latched_front_right <= latched_front_right_next;
      latched_front_left  <= latched_front_left_next;
      if (ctrl_run) begin
        prev_right <= latched_right;
        prev_left  <= latched_left;
      end
      error_reg       <= error_next;
      drive_right_reg <= drive_right_next;
      drive_left_reg  <= drive_left_next;
    end
  end

  // Result register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      phase_done  <= phase;
      drive_right <= drive_right_next;
      drive_left  <= drive_left_next;
      steer_error <= error_next;
      wall_bits   <= wall_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_side_to_front: assert property (@(posedge clk) disable iff (rst)
    in_accept && phase == wssc_pkg::PH_SIDE |=> phase == wssc_pkg::PH_FRONT)
    else $error("phase did not advance from side to front");

  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    lat_ctrl && !ctrl_enable |=> drive_right_reg == '0 && drive_left_reg == '0)
    else $error("disabled control step left drives nonzero");

  a_drive_opposite: assert property (@(posedge clk) disable iff (rst)
    (drive_right_reg + drive_left_reg == 0) || (drive_right_reg + drive_left_reg == -1))
    else $error("drive corrections are not opposite");
`endif

endmodule

`default_nettype wire
